// ===== src/cdc_pkg.sv =====
// ----------------------------------------------------------------------------
// cdc_pkg
// shared types, constants and helpers for the calendar date counter
// ----------------------------------------------------------------------------
package cdc_pkg;

  localparam int YEAR_BITS = 16;
  localparam int ADD_BITS  = 16;
  localparam int ACC_BITS  = ((ADD_BITS > 6) ? ADD_BITS : 6) + 1;

  localparam int F_DAY_BITS   = 6;
  localparam int F_MONTH_BITS = 4;
  localparam int F_YEAR_BITS  = 16;
  localparam int F_ADD_BITS   = 16;
  localparam int O_DAY_BITS   = 5;
  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 32;
  localparam int O_PAD_BITS =
    OUT_DATA_BITS - O_DAY_BITS - F_MONTH_BITS - F_YEAR_BITS;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_INC  = 2'd1;
  localparam logic [1:0] REQ_ADD  = 2'd2;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAP_MUL,
    S_LEAP_CHK,
    S_CLAMP,
    S_STEP,
    S_OUT
  } cdc_state_t;

  typedef struct packed {
    logic calc;
    logic latch;
  } leap_ctl_t;

  // inverse of an odd constant modulo 2^YEAR_BITS by newton steps
  function automatic logic [YEAR_BITS-1:0] odd_inverse_f(input logic [YEAR_BITS-1:0] d);
    logic [YEAR_BITS-1:0] x;
    x = d;
    for (int i = 0; i < 5; i++) begin
      x = YEAR_BITS'(x * (YEAR_BITS'(2) - YEAR_BITS'(d * x)));
    end
    return x;
  endfunction

  localparam logic [YEAR_BITS-1:0] DIV_CONST = YEAR_BITS'(25);
  localparam logic [YEAR_BITS-1:0] INV25 = odd_inverse_f(DIV_CONST);
  localparam logic [63:0] DIV25_LIM_W = ((64'd1 << YEAR_BITS) - 64'd1) / 64'd25;
  localparam logic [YEAR_BITS-1:0] DIV25_LIM = DIV25_LIM_W[YEAR_BITS-1:0];

  function automatic logic [4:0] month_len_f(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== src/cdc_leap_unit.sv =====
// ----------------------------------------------------------------------------
// cdc_leap_unit
// two-step leap year test: reciprocal multiply, then divisibility compare
// ----------------------------------------------------------------------------
module cdc_leap_unit
  import cdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  leap_ctl_t            ctl,
  input  logic [YEAR_BITS-1:0] year,
  output logic                 leap
);

  logic [YEAR_BITS-1:0] prod_r;
  logic [3:0]           low_r;
  logic                 leap_r;
  logic                 leap_nxt;
  logic                 div25;

  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      prod_r <= YEAR_BITS'(year * INV25);
      low_r  <= year[3:0];
    end
  end

  // divisible by 25 exactly when the modular product stays in range
  assign div25    = (prod_r <= DIV25_LIM);
  assign leap_nxt = (low_r[1:0] == 2'd0) && (!div25 || (low_r == 4'd0));

  // year zero after reset is a leap year
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leap_r <= 1'b1;
    end else if (ctl.latch) begin
      leap_r <= leap_nxt;
    end
  end

  assign leap = leap_r;

endmodule

// ===== src/calendar_date_counter.sv =====
// ----------------------------------------------------------------------------
// calendar_date_counter
// gregorian date register with load, increment and add-days requests
// ----------------------------------------------------------------------------
// Every accepted request returns one result transaction with the date after
// it. A load passes through the leap test (S_LEAP_MUL, S_LEAP_CHK) and the
// clamp state before the output register is written. An increment or an add
// runs the month-step loop, which runs one subtract and compare of the day
// count against the month length per cycle, moves on to the next month while
// the count exceeds the month length, and reruns the leap test after each
// year change. The input is not ready while a request is being worked on; a
// finished result waits in the output register while the next request is
// taken.
module calendar_date_counter
  import cdc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // set_day[5:0], set_month[9:6], set_year[25:10], days_to_add[41:26]
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [1:0]               in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // out_day[4:0], out_month[8:5], out_year[24:9]
  output logic [OUT_DATA_BITS-1:0] out_tdata
);

  cdc_state_t state_r, state_nxt;
  logic [ACC_BITS-1:0]      acc_r, acc_nxt;
  logic [3:0]               month_r, month_nxt;
  logic [YEAR_BITS-1:0]     year_r, year_nxt;
  logic [O_DAY_BITS-1:0]    day_r, day_nxt;
  logic                     load_r, load_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_DATA_BITS-1:0] out_data_r, out_data_nxt;

  leap_ctl_t                leap_ctl;
  logic                     leap;
  logic [4:0]               lim;
  logic [ACC_BITS-1:0]      lim_w;
  logic [F_DAY_BITS-1:0]    in_day;
  logic [F_MONTH_BITS-1:0]  in_month;
  logic [F_YEAR_BITS-1:0]   in_year;
  logic [F_ADD_BITS-1:0]    in_add;
  logic                     in_fire;

  assign in_day   = in_tdata[5:0];
  assign in_month = in_tdata[9:6];
  assign in_year  = in_tdata[25:10];
  assign in_add   = in_tdata[41:26];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  cdc_leap_unit u_leap (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (leap_ctl),
    .year  (year_r),
    .leap  (leap)
  );

  // shared month-length compare
  assign lim   = month_len_f(month_r, leap);
  assign lim_w = ACC_BITS'(lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      month_r     <= MON_JAN;
      year_r      <= '0;
      day_r       <= O_DAY_BITS'(1);
      load_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
      day_r       <= day_nxt;
      load_r      <= load_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    day_nxt       = day_r;
    load_nxt      = load_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    leap_ctl      = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            REQ_LOAD: begin
              load_nxt = 1'b1;
              acc_nxt  = ACC_BITS'(in_day);
              year_nxt = YEAR_BITS'(in_year);
              if (in_month == 4'd0) begin
                month_nxt = MON_JAN;
              end else if (in_month > MON_DEC) begin
                month_nxt = MON_DEC;
              end else begin
                month_nxt = in_month;
              end
              state_nxt = S_LEAP_MUL;
            end
            REQ_INC: begin
              load_nxt  = 1'b0;
              acc_nxt   = ACC_BITS'(day_r) + ACC_BITS'(1);
              state_nxt = S_STEP;
            end
            REQ_ADD: begin
              load_nxt  = 1'b0;
              acc_nxt   = ACC_BITS'(day_r) + ACC_BITS'(ADD_BITS'(in_add));
              state_nxt = S_STEP;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_LEAP_MUL: begin
        leap_ctl.calc = 1'b1;
        state_nxt     = S_LEAP_CHK;
      end
      S_LEAP_CHK: begin
        leap_ctl.latch = 1'b1;
        state_nxt      = load_r ? S_CLAMP : S_STEP;
      end
      S_CLAMP: begin
        if (acc_r == '0) begin
          day_nxt = O_DAY_BITS'(1);
        end else if (acc_r > lim_w) begin
          day_nxt = lim;
        end else begin
          day_nxt = acc_r[O_DAY_BITS-1:0];
        end
        state_nxt = S_OUT;
      end
      S_STEP: begin
        if (acc_r > lim_w) begin
          acc_nxt = acc_r - lim_w;
          if (month_r >= MON_DEC) begin
            month_nxt = MON_JAN;
            year_nxt  = year_r + YEAR_BITS'(1);
            state_nxt = S_LEAP_MUL;
          end else begin
            month_nxt = month_r + 4'd1;
          end
        end else begin
          day_nxt   = acc_r[O_DAY_BITS-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {O_PAD_BITS'(0), F_YEAR_BITS'(year_r), month_r, day_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// testbench for the calendar date counter: a set of directed requests covers
// the clamping of loads, the leap year rules, month and year rollover, the
// wrap of the year and the add path. A long random run follows. Every result
// transaction is checked field by field against a date model kept inside the
// testbench, while both stream sides stall and idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import cdc_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } date_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic [1:0]               in_tuser = REQ_LOAD;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;

  date_t date_q[$];
  int    err_cnt = 0;
  int    cycle_cnt = 0;
  int    stall_cnt = 0;
  bit    idle_on = 1'b1;

  // date model
  int model_day = 1;
  int model_month = 1;
  int model_year = 0;

  calendar_date_counter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic bit is_leap_year(int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int month_days(int m, int y);
    int len;
    case (m)
      2: len = is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  function automatic void roll_month();
    model_month++;
    if (model_month > 12) begin
      model_month = 1;
      model_year = (model_year + 1) & 16'hffff;
    end
  endfunction

  function automatic date_t next_date(logic [1:0] kind, logic [5:0] d_in,
                                      logic [3:0] m_in, logic [15:0] y_in,
                                      logic [15:0] n_in);
    int    d;
    int    m;
    int    lim;
    date_t res;
    case (kind)
      REQ_LOAD: begin
        d = d_in;
        m = m_in;
        model_year = y_in;
        if (m < 1) m = 1;
        else if (m > 12) m = 12;
        lim = month_days(m, model_year);
        if (d < 1) d = 1;
        else if (d > lim) d = lim;
        model_month = m;
        model_day = d;
      end
      REQ_INC: begin
        model_day++;
        if (model_day > month_days(model_month, model_year)) begin
          model_day = 1;
          roll_month();
        end
      end
      REQ_ADD: begin
        d = model_day + n_in;
        lim = month_days(model_month, model_year);
        while (d > lim) begin
          d -= lim;
          roll_month();
          lim = month_days(model_month, model_year);
        end
        model_day = d;
      end
      default: ;
    endcase
    res.day = model_day[4:0];
    res.month = model_month[3:0];
    res.year = model_year[15:0];
    return res;
  endfunction

  task automatic report(string msg);
    $display("tb_top: mismatch: %s", msg);
    err_cnt++;
  endtask

  task automatic send_req(logic [1:0] kind, logic [5:0] d, logic [3:0] m,
                          logic [15:0] y, logic [15:0] n);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {6'b0, n, y, m, d};
    do @(posedge clk); while (!in_tready);
    date_q.push_back(next_date(kind, d, m, y, n));
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (date_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_req(REQ_NONE, 6'd63, 4'd15, 16'hffff, 16'hffff);
    send_req(REQ_ADD, 6'd0, 4'd0, 16'd0, 16'd0);
  endtask

  task automatic test_load_clamp();
    send_req(REQ_LOAD, 6'd0, 4'd0, 16'd2023, 16'd0);
    send_req(REQ_LOAD, 6'd63, 4'd15, 16'hffff, 16'hffff);
    send_req(REQ_LOAD, 6'd31, 4'd4, 16'd2024, 16'd0);
    send_req(REQ_LOAD, 6'd40, 4'd13, 16'd1999, 16'd0);
  endtask

  task automatic test_leap_rules();
    send_req(REQ_LOAD, 6'd29, 4'd2, 16'd0, 16'd0);
    send_req(REQ_LOAD, 6'd30, 4'd2, 16'd1900, 16'd0);
    send_req(REQ_LOAD, 6'd29, 4'd2, 16'd2000, 16'd0);
    send_req(REQ_LOAD, 6'd29, 4'd2, 16'd2023, 16'd0);
    send_req(REQ_LOAD, 6'd28, 4'd2, 16'd2024, 16'd0);
    send_req(REQ_INC, 6'd0, 4'd0, 16'd0, 16'd0);
    send_req(REQ_INC, 6'd0, 4'd0, 16'd0, 16'd0);
  endtask

  task automatic test_rollover();
    send_req(REQ_LOAD, 6'd31, 4'd12, 16'hffff, 16'd0);
    send_req(REQ_INC, 6'd0, 4'd0, 16'd0, 16'd0);
    send_req(REQ_LOAD, 6'd30, 4'd4, 16'd1234, 16'd0);
    send_req(REQ_INC, 6'd0, 4'd0, 16'd0, 16'd0);
    send_req(REQ_NONE, 6'd0, 4'd0, 16'd0, 16'd0);
  endtask

  task automatic test_add_days();
    send_req(REQ_ADD, 6'd0, 4'd0, 16'd0, 16'd0);
    send_req(REQ_ADD, 6'd0, 4'd0, 16'd0, 16'hffff);
    send_req(REQ_LOAD, 6'd1, 4'd1, 16'hffff, 16'd0);
    send_req(REQ_ADD, 6'd0, 4'd0, 16'd0, 16'd400);
    send_req(REQ_ADD, 6'd0, 4'd0, 16'd0, 16'd1);
  endtask

  task automatic test_random(int count);
    int          r;
    logic [1:0]  kind;
    logic [5:0]  d;
    logic [3:0]  m;
    logic [15:0] y;
    logic [15:0] n;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (i % 60 == 59) wait_results();
      r = $urandom_range(0, 9);
      d = 6'($urandom_range(0, 63));
      m = 4'($urandom_range(0, 15));
      y = 16'($urandom_range(0, 65535));
      n = 16'($urandom_range(0, 65535));
      if (r <= 2) begin
        kind = REQ_LOAD;
        // month ends and the top of the year range get extra weight
        if ($urandom_range(0, 9) < 3) begin
          d = 6'($urandom_range(27, 31));
          m = 4'($urandom_range(1, 12));
        end
        if ($urandom_range(0, 3) == 0) y = 16'($urandom_range(65530, 65535));
      end else if (r <= 5) begin
        kind = REQ_INC;
      end else if (r <= 8) begin
        kind = REQ_ADD;
        r = $urandom_range(0, 99);
        if (r >= 97) n = 16'($urandom_range(0, 65535));
        else if (r >= 90) n = 16'($urandom_range(0, 3000));
        else n = 16'($urandom_range(0, 400));
      end else begin
        kind = REQ_NONE;
      end
      send_req(kind, d, m, y, n);
    end
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_cnt <= 0;
    end else if (out_tvalid && out_tready) begin
      stall_cnt <= idle_on ? $urandom_range(0, 15) : 0;
      out_tready <= 1'b0;
    end else if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    date_t exp_date;
    date_t got_date;
    if (rst_n && out_tvalid && out_tready) begin
      got_date.day = out_tdata[4:0];
      got_date.month = out_tdata[8:5];
      got_date.year = out_tdata[24:9];
      if (date_q.size() == 0) begin
        report($sformatf("unexpected result %0d/%0d/%0d", got_date.day,
                         got_date.month, got_date.year));
      end else begin
        exp_date = date_q.pop_front();
        if (got_date.day != exp_date.day)
          report($sformatf("day got %0d exp %0d", got_date.day, exp_date.day));
        if (got_date.month != exp_date.month)
          report($sformatf("month got %0d exp %0d", got_date.month, exp_date.month));
        if (got_date.year != exp_date.year)
          report($sformatf("year got %0d exp %0d", got_date.year, exp_date.year));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_load_clamp();
    wait_results();
    test_leap_rules();
    test_rollover();
    wait_results();
    test_add_days();
    test_random(230);
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cdc_pkg.sv
src/cdc_leap_unit.sv
src/calendar_date_counter.sv
dv/tb_top.sv
